// ===== hw/rtl/lna_pkg.sv =====
// Shared types and constants for the line assembler.
`default_nettype none
package lna_pkg;

	localparam int LINE_BYTES_DEF = 64;
	localparam int TAKE_LIMIT_W = 7;
	localparam logic [TAKE_LIMIT_W-1:0] TAKE_LIMIT_RST = 7'd64;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_LINE = 2'd1,
		ACT_OVF  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_LAST = 3'b100
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/line_assembler_with_overflow.sv =====
// Line assembler top level: byte intake, flags, line store and line readout.
// A push transfer gives no result; pushes are accepted every cycle while no line is read out.
// A refused take, an empty take or a take-overflow request gives its result in the cycle after the transfer.
// A take-line request blocks input and sends its bytes from the single read port of the
// line store via a holding register, one byte per cycle unless the output stalls.
// Reset clears all flags and the fill count and sets take_limit to 64; the store is not cleared.
`default_nettype none
module line_assembler_with_overflow #(
	parameter int LINE_BYTES = lna_pkg::LINE_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  wire logic [1:0]                      s_axis_tuser,  // [1:0] action
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic      [7:0]                      m_axis_tdata,  // [7:0] line_byte
	output logic      [1:0]                      m_axis_tuser,  // [0] success, [1] has_byte
	output logic                                 m_axis_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lna_pkg::TAKE_LIMIT_W-1:0] cfg_data
);

	localparam int AW = $clog2(LINE_BYTES);
	localparam int TW = lna_pkg::TAKE_LIMIT_W;
	localparam logic [AW-1:0] FILL_MAX = AW'(LINE_BYTES - 1);

	lna_pkg::state_t state_q;
	lna_pkg::action_t act;

	logic [AW-1:0] fill_q;
	logic          ready_q;
	logic          disc_q;
	logic          ovf_q;
	logic          last_cr_q;
	logic [TW-1:0] take_limit_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] idx_d;
	logic [AW-1:0] nxt_idx;
	logic [AW-1:0] lim_q;
	logic [AW-1:0] lim_w;
	logic [TW-1:0] tl_m1;
	logic [7:0]    cur_q;
	logic          cur_vld_q;
	logic [7:0]    rdata_s1;
	logic          at_end;
	logic          line_ok;
	logic          free;
	logic          in_xfer;
	logic          is_lf;
	logic          we;

	logic          emit;
	logic          e_succ;
	logic          e_has;
	logic [7:0]    e_byte;
	logic          e_last;

	logic          m_valid_q;
	logic [7:0]    m_data_q;
	logic [1:0]    m_user_q;
	logic          m_last_q;

	assign act = lna_pkg::action_t'(s_axis_tuser);
	assign free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == lna_pkg::ST_IDLE) &&
		(free || act == lna_pkg::ACT_PUSH || act == lna_pkg::ACT_NONE);
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign is_lf = (s_axis_tdata == lna_pkg::CH_LF);

	assign tl_m1 = take_limit_q - TW'(1);
	assign lim_w = (tl_m1 < TW'(fill_q)) ? tl_m1[AW-1:0] : fill_q;
	assign line_ok = (take_limit_q != '0) && ready_q;
	assign nxt_idx = idx_q + AW'(1);
	assign at_end = (nxt_idx == lim_q);

	assign we = in_xfer && (act == lna_pkg::ACT_PUSH) && !disc_q && !ready_q && !is_lf &&
		(fill_q != FILL_MAX);

	assign cfg_ready = 1'b1;

	lna_line_mem #(
		.DEPTH(LINE_BYTES)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (fill_q),
		.wdata (s_axis_tdata),
		.raddr (idx_d),
		.rdata (rdata_s1)
	);

	always_comb begin
		emit = 1'b0;
		e_succ = 1'b0;
		e_has = 1'b0;
		e_byte = '0;
		e_last = 1'b1;
		idx_d = idx_q;
		case (state_q)
			lna_pkg::ST_IDLE: begin
				if (in_xfer) begin
					case (act)
						lna_pkg::ACT_LINE: begin
							if (!line_ok) begin
								emit = 1'b1;
							end else if (lim_w == '0) begin
								emit = 1'b1;
								e_succ = 1'b1;
							end else begin
								idx_d = '0;
							end
						end
						lna_pkg::ACT_OVF: begin
							emit = 1'b1;
							e_succ = ovf_q;
						end
						default: begin
						end
					endcase
				end
			end
			lna_pkg::ST_RD: begin
				if (free) begin
					if (cur_vld_q) begin
						emit = 1'b1;
						e_succ = 1'b1;
						e_has = 1'b1;
						e_byte = cur_q;
						e_last = (rdata_s1 == '0);
					end else if (rdata_s1 == '0) begin
						emit = 1'b1;
						e_succ = 1'b1;
					end
					if (rdata_s1 != '0 && !at_end) begin
						idx_d = nxt_idx;
					end
				end
			end
			lna_pkg::ST_LAST: begin
				if (free) begin
					emit = 1'b1;
					e_succ = 1'b1;
					e_has = 1'b1;
					e_byte = cur_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lna_pkg::ST_IDLE;
			fill_q <= '0;
			ready_q <= 1'b0;
			disc_q <= 1'b0;
			ovf_q <= 1'b0;
			last_cr_q <= 1'b0;
			take_limit_q <= lna_pkg::TAKE_LIMIT_RST;
			idx_q <= '0;
			lim_q <= '0;
			cur_vld_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cfg_valid) begin
				take_limit_q <= cfg_data;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				lna_pkg::ST_IDLE: begin
					if (in_xfer) begin
						case (act)
							lna_pkg::ACT_PUSH: begin
								if (disc_q) begin
									if (is_lf) begin
										disc_q <= 1'b0;
										ovf_q <= 1'b1;
									end
								end else if (ready_q) begin
									if (is_lf) begin
										ovf_q <= 1'b1;
									end
								end else if (is_lf) begin
									if (fill_q != '0 && last_cr_q) begin
										fill_q <= fill_q - AW'(1);
									end
									ready_q <= 1'b1;
								end else if (fill_q == FILL_MAX) begin
									fill_q <= '0;
									disc_q <= 1'b1;
								end else begin
									fill_q <= fill_q + AW'(1);
									last_cr_q <= (s_axis_tdata == lna_pkg::CH_CR);
								end
							end
							lna_pkg::ACT_LINE: begin
								if (line_ok) begin
									fill_q <= '0;
									ready_q <= 1'b0;
									if (lim_w != '0) begin
										lim_q <= lim_w;
										cur_vld_q <= 1'b0;
										state_q <= lna_pkg::ST_RD;
									end
								end
							end
							lna_pkg::ACT_OVF: begin
								ovf_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				lna_pkg::ST_RD: begin
					if (free) begin
						if (rdata_s1 == '0) begin
							state_q <= lna_pkg::ST_IDLE;
						end else begin
							cur_vld_q <= 1'b1;
							if (at_end) begin
								state_q <= lna_pkg::ST_LAST;
							end
						end
					end
				end
				lna_pkg::ST_LAST: begin
					if (free) begin
						state_q <= lna_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lna_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lna_pkg::ST_RD && free && rdata_s1 != '0) begin
			cur_q <= rdata_s1;
		end
		if (emit) begin
			m_data_q <= e_byte;
			m_user_q <= {e_has, e_succ};
			m_last_q <= e_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;
	assign m_axis_tlast = m_last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lna_line_mem.sv =====
// Line store: one write port and one registered read port.
`default_nettype none
module lna_line_mem #(
	parameter int DEPTH = lna_pkg::LINE_BYTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the line assembler: directed table, then random line traffic.
`timescale 1ns / 1ps

module testbench;
	import lna_pkg::*;

	localparam int LINE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int IDLE_PCT = 38;
	localparam int PHASE_ITEMS = 64;

	typedef struct packed {
		logic       success;
		logic       has_byte;
		logic [7:0] line_byte;
		logic       last;
	} line_res_t;

	typedef struct packed {
		action_t    act;
		logic [7:0] data;
		logic       pinned;
		line_res_t  res;
	} script_row_t;

	localparam line_res_t RES_FAIL = '{1'b0, 1'b0, 8'h00, 1'b1};
	localparam line_res_t RES_OK_EMPTY = '{1'b1, 1'b0, 8'h00, 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;  // [7:0] data_byte
	logic [1:0] s_axis_tuser = 2'd0;   // [1:0] action
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [7:0] line_byte
	logic [1:0] m_axis_tuser;          // [0] success, [1] has_byte
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [TAKE_LIMIT_W-1:0] cfg_data = '0;

	logic calm = 1'b0;
	logic pinned = 1'b0;
	line_res_t pinned_res = RES_FAIL;

	logic [7:0] line_copy [LINE_DEPTH];
	int unsigned fill_copy = 0;
	bit ready_copy = 1'b0;
	bit discard_copy = 1'b0;
	bit ovf_copy = 1'b0;
	logic [TAKE_LIMIT_W-1:0] limit_copy = TAKE_LIMIT_RST;

	line_res_t line_bytes_due [$];
	int errors = 0;
	int items_sent = 0;
	int cycles = 0;

	script_row_t script [0:21] = '{
		'{ACT_LINE, 8'h00, 1'b1, RES_FAIL},
		'{ACT_OVF,  8'hFF, 1'b1, RES_FAIL},
		'{ACT_NONE, 8'hFF, 1'b0, RES_FAIL},
		'{ACT_PUSH, 8'hFF, 1'b0, RES_FAIL},
		'{ACT_PUSH, 8'h41, 1'b0, RES_FAIL},
		'{ACT_PUSH, CH_CR, 1'b0, RES_FAIL},
		'{ACT_PUSH, CH_LF, 1'b0, RES_FAIL},
		'{ACT_PUSH, 8'h7E, 1'b0, RES_FAIL},
		'{ACT_PUSH, CH_LF, 1'b0, RES_FAIL},
		'{ACT_LINE, 8'h00, 1'b0, RES_FAIL},
		'{ACT_OVF,  8'h00, 1'b1, RES_OK_EMPTY},
		'{ACT_OVF,  8'h00, 1'b1, RES_FAIL},
		'{ACT_PUSH, 8'h00, 1'b0, RES_FAIL},
		'{ACT_PUSH, 8'h55, 1'b0, RES_FAIL},
		'{ACT_PUSH, CH_LF, 1'b0, RES_FAIL},
		'{ACT_LINE, 8'hAA, 1'b1, RES_OK_EMPTY},
		'{ACT_PUSH, CH_LF, 1'b0, RES_FAIL},
		'{ACT_LINE, 8'h00, 1'b1, RES_OK_EMPTY},
		'{ACT_PUSH, CH_CR, 1'b0, RES_FAIL},
		'{ACT_PUSH, CH_CR, 1'b0, RES_FAIL},
		'{ACT_PUSH, CH_LF, 1'b0, RES_FAIL},
		'{ACT_LINE, 8'h00, 1'b0, RES_FAIL}
	};

	line_assembler_with_overflow u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void assemble_byte(input logic [7:0] b);
		if (discard_copy) begin
			if (b == CH_LF) begin
				discard_copy = 1'b0;
				ovf_copy = 1'b1;
			end
		end else if (ready_copy) begin
			if (b == CH_LF)
				ovf_copy = 1'b1;
		end else if (b == CH_LF) begin
			if (fill_copy > 0 && line_copy[fill_copy - 1] == CH_CR)
				fill_copy--;
			ready_copy = 1'b1;
		end else if (fill_copy + 1 >= LINE_DEPTH) begin
			fill_copy = 0;
			discard_copy = 1'b1;
		end else begin
			line_copy[fill_copy] = b;
			fill_copy++;
		end
	endfunction

	function automatic void predict_request(input action_t act, input logic [7:0] b);
		int unsigned lim;
		int unsigned n;
		case (act)
			ACT_PUSH: assemble_byte(b);
			ACT_LINE: begin
				if (limit_copy == 0 || !ready_copy) begin
					line_bytes_due.push_back(RES_FAIL);
				end else begin
					lim = limit_copy - 1;
					if (lim > fill_copy)
						lim = fill_copy;
					n = 0;
					while (n < lim && line_copy[n] != 8'h00)
						n++;
					fill_copy = 0;
					ready_copy = 1'b0;
					if (n == 0)
						line_bytes_due.push_back(RES_OK_EMPTY);
					for (int k = 0; k < n; k++)
						line_bytes_due.push_back('{1'b1, 1'b1, line_copy[k], k == n - 1});
				end
			end
			ACT_OVF: begin
				line_bytes_due.push_back('{ovf_copy, 1'b0, 8'h00, 1'b1});
				ovf_copy = 1'b0;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		line_res_t got;
		line_res_t want;
		int depth;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata, m_axis_tlast};
				if (line_bytes_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: success=%0d has_byte=%0d byte=%02h last=%0d",
							got.success, got.has_byte, got.line_byte, got.last);
				end else begin
					want = line_bytes_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: expected success=%0d has_byte=%0d byte=%02h ",
								"last=%0d, got success=%0d has_byte=%0d byte=%02h last=%0d"},
								want.success, want.has_byte, want.line_byte, want.last,
								got.success, got.has_byte, got.line_byte, got.last);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				limit_copy = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				depth = line_bytes_due.size();
				predict_request(action_t'(s_axis_tuser), s_axis_tdata);
				if (pinned) begin
					while (line_bytes_due.size() > depth)
						void'(line_bytes_due.pop_back());
					line_bytes_due.push_back(pinned_res);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(19))
			0: return 8'h00;
			1: return CH_CR;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic send_item(input action_t act, input logic [7:0] b,
		input logic pin = 1'b0, input line_res_t res = RES_FAIL);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while (!calm && $urandom_range(99) < IDLE_PCT);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= b;
		pinned <= pin;
		pinned_res <= res;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (act != ACT_NONE)
			items_sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (line_bytes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [TAKE_LIMIT_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A line of random content ended by LF, followed by occasional noise and take requests.
	task automatic send_line(input int len);
		int r;
		for (int i = 0; i < len; i++)
			send_item(ACT_PUSH, pick_byte());
		if ($urandom_range(3) == 0)
			send_item(ACT_PUSH, CH_CR);
		send_item(ACT_PUSH, CH_LF);
		r = $urandom_range(15);
		if (r == 0)
			send_item(ACT_PUSH, pick_byte());
		else if (r == 1)
			send_item(ACT_PUSH, CH_LF);
		else if (r == 2)
			send_item(ACT_NONE, pick_byte());
		else if (r == 3)
			send_item(ACT_OVF, pick_byte());
		if ($urandom_range(9) != 0)
			send_item(ACT_LINE, pick_byte());
		if ($urandom_range(5) == 0)
			send_item(ACT_OVF, pick_byte());
	endtask

	task automatic run_phase(input logic [TAKE_LIMIT_W-1:0] value, input bit long_first);
		int goal;
		write_limit(value);
		goal = items_sent + PHASE_ITEMS;
		if (long_first) begin
			send_line(LINE_DEPTH - 1);
			send_line(LINE_DEPTH);
		end
		while (items_sent < goal)
			send_line(($urandom_range(7) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i])
			send_item(script[i].act, script[i].data, script[i].pinned, script[i].res);
		run_phase(7'd0, 1'b0);
		run_phase(7'd1, 1'b0);
		run_phase(7'd2, 1'b0);
		calm <= 1'b1;
		run_phase(7'd63, 1'b0);
		calm <= 1'b0;
		run_phase(7'($urandom_range(3, 62)), 1'b0);
		run_phase(7'd64, 1'b1);
		settle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lna_pkg.sv
hw/rtl/lna_line_mem.sv
hw/rtl/line_assembler_with_overflow.sv
dv/testbench.sv
